FILE: rtl/assert_macros.svh
// Assertion macros for the port-level checker of this project (sprp_checker).
// No dependencies; take in by include before the module that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in the same cycle as the consequent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/sprp_pkg.sv
// Shared types and constants of the strong probable prime test.
// No dependencies; compile before every other file of the block.
package sprp_pkg;

  localparam int NUM_WIDTH_DEF = 32;
  localparam int OPND_W        = 32;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 3;

  // Register index as seen on paddr[2].
  localparam logic REG_WITNESS_BASE = 1'b0;
  localparam logic [CFG_DATA_W-1:0] WITNESS_BASE_RST = 32'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STRIP,
    S_REDUCE,
    S_EXP_TEST,
    S_MUL_X,
    S_MUL_B,
    S_SQ_TEST,
    S_MUL_SQ,
    S_DONE
  } sprp_state_t;

endpackage

FILE: rtl/sprp_mulmod.sv
// Bit-serial modular multiplier: (a * b) mod n, one bit of a per cycle.
// Depends on sprp_pkg. Requires b < n and n >= 2; n and b held by the caller.
module sprp_mulmod import sprp_pkg::*; #(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [OPND_W-1:0]    opnd_a,
  input  logic [NUM_WIDTH-1:0] opnd_b,
  input  logic [NUM_WIDTH-1:0] modulus,
  output logic                 done,
  output logic [NUM_WIDTH-1:0] result
);

  localparam int CNT_W = $clog2(OPND_W);
  localparam int T_W   = NUM_WIDTH + 2;

  logic [OPND_W-1:0]    a_sr_r, a_sr_nxt;
  logic [NUM_WIDTH-1:0] b_r, b_nxt;
  logic [NUM_WIDTH-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [T_W-1:0] t_sum;
  logic [T_W-1:0] n1;
  logic [T_W-1:0] n2;
  logic [T_W-1:0] t_red;

  // acc < n and b < n, so 2*acc + b < 3n: at most two subtractions of n.
  always_comb begin
    n1    = T_W'(modulus);
    n2    = n1 << 1;
    t_sum = (T_W'(acc_r) << 1) + (a_sr_r[OPND_W-1] ? T_W'(b_r) : '0);
    if (t_sum >= n2) begin
      t_red = t_sum - n2;
    end else if (t_sum >= n1) begin
      t_red = t_sum - n1;
    end else begin
      t_red = t_sum;
    end
  end

  always_comb begin
    a_sr_nxt = a_sr_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (go) begin
      a_sr_nxt = opnd_a;
      b_nxt    = opnd_b;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      a_sr_nxt = a_sr_r << 1;
      acc_nxt  = t_red[NUM_WIDTH-1:0];
      cnt_nxt  = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(OPND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_sr_r <= a_sr_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

FILE: rtl/strong_probable_prime_test_top.sv
// Strong probable prime test (Miller-Rabin, one base). One candidate at a time:
// after a transfer on the input the block writes n-1 as d*2^s, reduces the base
// mod n, runs square-and-multiply over d and then up to s squarings, and offers
// one result. Every modular multiplication runs in one shared bit-serial unit
// that steps through all 32 bits of the multiplier operand; candidates below two
// skip the arithmetic and go straight to the result. The input opens again in
// the cycle the result shows.
// A result waiting on out_stall does not hold off the next candidate; it only
// holds the block once that candidate's result is ready.
// Depends on sprp_pkg and sprp_mulmod.
module strong_probable_prime_test_top import sprp_pkg::*; #(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [31:0]           in_candidate,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_probable_prime,
  output logic                  out_invalid_candidate,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int SW = $clog2(NUM_WIDTH);

  sprp_state_t state_r, state_nxt;

  logic [CFG_DATA_W-1:0] witness_base_r;
  logic [NUM_WIDTH-1:0]  n_r, d_r, x_r, b_r;
  logic [SW-1:0]         s_r, r_r;
  logic                  res_r, inv_r;
  logic                  out_valid_r, out_pp_r, out_inv_r;
  logic                  go_r, go_nxt;

  logic [NUM_WIDTH-1:0] cand_n;
  logic [NUM_WIDTH-1:0] n_minus_1;
  logic                 cand_small;
  logic                 out_free;
  logic                 out_load;
  logic                 cfg_wr;

  logic [OPND_W-1:0]    mul_a;
  logic [NUM_WIDTH-1:0] mul_b;
  logic                 mul_done;
  logic [NUM_WIDTH-1:0] mul_res;

  assign cand_n     = in_candidate[NUM_WIDTH-1:0];
  assign cand_small = (cand_n[NUM_WIDTH-1:1] == '0);
  assign n_minus_1  = n_r - NUM_WIDTH'(1);

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_WITNESS_BASE);
  assign cfg_prdata = (cfg_paddr[2] == REG_WITNESS_BASE) ? witness_base_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      witness_base_r <= WITNESS_BASE_RST;
    end else if (cfg_wr) begin
      witness_base_r <= cfg_pwdata;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = cand_small ? S_DONE : S_STRIP;
      end
      S_STRIP: begin
        if (d_r[0]) state_nxt = S_REDUCE;
      end
      S_REDUCE: begin
        if (mul_done) state_nxt = S_EXP_TEST;
      end
      S_EXP_TEST: begin
        if (d_r == '0) begin
          state_nxt = (x_r == NUM_WIDTH'(1)) ? S_DONE : S_SQ_TEST;
        end else if (d_r[0]) begin
          state_nxt = S_MUL_X;
        end else begin
          state_nxt = S_MUL_B;
        end
      end
      S_MUL_X: begin
        if (mul_done) state_nxt = S_MUL_B;
      end
      S_MUL_B: begin
        if (mul_done) state_nxt = S_EXP_TEST;
      end
      S_SQ_TEST: begin
        state_nxt = (r_r == s_r || x_r == n_minus_1) ? S_DONE : S_MUL_SQ;
      end
      S_MUL_SQ: begin
        if (mul_done) state_nxt = S_SQ_TEST;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall = (state_r != S_IDLE);
    out_free = !out_valid_r || !out_stall;
    out_load = (state_r == S_DONE) && out_free;
    // launch the multiplier on entry to any multiply state
    go_nxt   = (state_nxt != state_r)
               && (state_nxt inside {S_REDUCE, S_MUL_X, S_MUL_B, S_MUL_SQ});
  end

  // Multiplier operands
  always_comb begin
    case (state_r)
      S_REDUCE: begin
        mul_a = witness_base_r;
        mul_b = NUM_WIDTH'(1);
      end
      S_MUL_X: begin
        mul_a = OPND_W'(x_r);
        mul_b = b_r;
      end
      S_MUL_B: begin
        mul_a = OPND_W'(b_r);
        mul_b = b_r;
      end
      default: begin
        mul_a = OPND_W'(x_r);
        mul_b = x_r;
      end
    endcase
  end

  sprp_mulmod #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go_r),
    .opnd_a  (mul_a),
    .opnd_b  (mul_b),
    .modulus (n_r),
    .done    (mul_done),
    .result  (mul_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pp_r  <= res_r;
      out_inv_r <= inv_r;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_r   <= cand_n;
          d_r   <= cand_n - NUM_WIDTH'(1);
          s_r   <= '0;
          res_r <= 1'b0;
          inv_r <= cand_small;
        end
      end
      S_STRIP: begin
        if (!d_r[0]) begin
          d_r <= d_r >> 1;
          s_r <= s_r + SW'(1);
        end
      end
      S_REDUCE: begin
        if (mul_done) begin
          b_r <= mul_res;
          x_r <= NUM_WIDTH'(1);
        end
      end
      S_EXP_TEST: begin
        if (d_r == '0) begin
          res_r <= (x_r == NUM_WIDTH'(1));
          r_r   <= '0;
        end
      end
      S_MUL_X: begin
        if (mul_done) x_r <= mul_res;
      end
      S_MUL_B: begin
        if (mul_done) begin
          b_r <= mul_res;
          d_r <= d_r >> 1;
        end
      end
      S_SQ_TEST: begin
        res_r <= (r_r != s_r) && (x_r == n_minus_1);
      end
      S_MUL_SQ: begin
        if (mul_done) begin
          x_r <= mul_res;
          r_r <= r_r + SW'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_valid             = out_valid_r;
  assign out_probable_prime    = out_pp_r;
  assign out_invalid_candidate = out_inv_r;

endmodule

FILE: rtl/sprp_checker.sv
// Port-level checker for the strong probable prime test, bound to the top level.
// Depends on sprp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sprp_checker import sprp_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [31:0]           in_candidate,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  out_probable_prime,
  input logic                  out_invalid_candidate,
  input logic                  cfg_psel,
  input logic                  cfg_penable,
  input logic                  cfg_pwrite,
  input logic [CFG_ADDR_W-1:0] cfg_paddr,
  input logic [CFG_DATA_W-1:0] cfg_pwdata,
  input logic [CFG_DATA_W-1:0] cfg_prdata,
  input logic                  cfg_pready
);

  // An invalid candidate never reports prime.
  `ASSERT_SAME(a_inv_not_prime, clk, rst_n, out_valid && out_invalid_candidate, !out_probable_prime)

  // One candidate at a time: a transfer in closes the input.
  `ASSERT_NEXT(a_in_closes, clk, rst_n, in_valid && !in_stall, in_stall)

  // A new result appears only while a candidate was in work.
  `ASSERT_SAME(a_out_from_work, clk, rst_n, out_valid && !$past(out_valid), $past(in_stall))

  // A stalled result holds.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_probable_prime) && $stable(out_invalid_candidate))

endmodule

bind strong_probable_prime_test_top sprp_checker u_sprp_checker (.*);

FILE: dv/sprp_result_checker.sv
`timescale 1ns / 1ps
// Result checker for strong_probable_prime_test_top: watches the config, input and result
// transfers, predicts each verdict and compares it field by field. Depends on sprp_pkg.
module sprp_result_checker import sprp_pkg::*; #(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [31:0]           in_candidate,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_probable_prime,
  input  logic                  out_invalid_candidate,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output int                    mismatch_count,
  output int                    verdicts_pending
);

  localparam logic [CFG_ADDR_W-1:0] BASE_ADDR = {REG_WITNESS_BASE, 2'b00};
  localparam logic [63:0] CAND_MASK = (64'd1 << NUM_WIDTH) - 64'd1;

  typedef struct packed {
    logic [31:0] candidate;
    logic        probable_prime;
    logic        invalid_candidate;
  } verdict_t;

  verdict_t    expected_verdicts[$];
  logic [31:0] witness_base;

  // n >= 2: write n-1 as d*2^s, raise the base to d, then look for n-1 in the squarings
  function automatic logic sprp_verdict(input logic [63:0] n, input logic [63:0] a);
    logic [63:0] d;
    logic [63:0] x;
    logic [63:0] b;
    int          s;
    int          r;
    d = n - 64'd1;
    s = 0;
    x = 64'd1;
    b = a % n;
    while (d[0] == 1'b0 && s < 64) begin
      d = d >> 1;
      s++;
    end
    while (d != 64'd0) begin
      if (d[0]) x = (x * b) % n;
      b = (b * b) % n;
      d = d >> 1;
    end
    if (x == 64'd1) return 1'b1;
    for (r = 0; r < s; r++) begin
      if (x == n - 64'd1) return 1'b1;
      x = (x * x) % n;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  initial begin
    mismatch_count   = 0;
    verdicts_pending = 0;
    witness_base     = WITNESS_BASE_RST;
  end

  always @(posedge clk) begin : watch
    verdict_t    want;
    logic [63:0] n;
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == BASE_ADDR) begin
        witness_base = cfg_pwdata;
      end
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result transfer with no candidate outstanding");
        end else begin
          want = expected_verdicts.pop_front();
          if (out_probable_prime !== want.probable_prime)
            report_mismatch($sformatf("candidate %0d: probable_prime expected %0b got %0b",
                                      want.candidate, want.probable_prime, out_probable_prime));
          if (out_invalid_candidate !== want.invalid_candidate)
            report_mismatch($sformatf("candidate %0d: invalid_candidate expected %0b got %0b",
                                      want.candidate, want.invalid_candidate,
                                      out_invalid_candidate));
        end
      end
      if (in_valid && !in_stall) begin
        n = {32'd0, in_candidate} & CAND_MASK;
        want.candidate = in_candidate;
        if (n < 64'd2) begin
          want.probable_prime    = 1'b0;
          want.invalid_candidate = 1'b1;
        end else begin
          want.probable_prime    = sprp_verdict(n, {32'd0, witness_base});
          want.invalid_candidate = 1'b0;
        end
        expected_verdicts.push_back(want);
      end
      verdicts_pending = expected_verdicts.size();
    end
  end

endmodule

FILE: dv/tb_strong_probable_prime_test_top.sv
`timescale 1ns / 1ps
// Testbench top for strong_probable_prime_test_top: drives candidates, base writes and
// result backpressure, and gives the verdict. Depends on sprp_pkg and sprp_result_checker.
module tb_strong_probable_prime_test_top;
  import sprp_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] BASE_ADDR = {REG_WITNESS_BASE, 2'b00};
  localparam int PHASE_ITEMS  = 20;
  localparam int DRAIN_CYCLES = 3400;

  localparam logic [31:0] DIRECTED [22] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd9, 32'd15, 32'd341, 32'd561,
    32'd2047, 32'd65537, 32'd3215031751, 32'h7FFF_FFFF, 32'hFFFF_FFFB, 32'hFFFF_FFFF,
    32'hFFFF_FFFE, 32'h8000_0000, 32'h8000_0001, 32'hC000_0001, 32'd8
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [31:0]           in_candidate = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_probable_prime;
  logic                  out_invalid_candidate;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int          mismatch_count;
  int          verdicts_pending;
  logic        in_burst = 1'b0;
  logic        out_burst = 1'b0;
  int          stall_left = 0;
  logic [31:0] cur_base = WITNESS_BASE_RST;

  always #5 clk = ~clk;

  strong_probable_prime_test_top uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_candidate         (in_candidate),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_probable_prime   (out_probable_prime),
    .out_invalid_candidate(out_invalid_candidate),
    .cfg_psel             (cfg_psel),
    .cfg_penable          (cfg_penable),
    .cfg_pwrite           (cfg_pwrite),
    .cfg_paddr            (cfg_paddr),
    .cfg_pwdata           (cfg_pwdata),
    .cfg_prdata           (cfg_prdata),
    .cfg_pready           (cfg_pready)
  );

  sprp_result_checker checker_i (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_candidate         (in_candidate),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_probable_prime   (out_probable_prime),
    .out_invalid_candidate(out_invalid_candidate),
    .cfg_psel             (cfg_psel),
    .cfg_penable          (cfg_penable),
    .cfg_pwrite           (cfg_pwrite),
    .cfg_pready           (cfg_pready),
    .cfg_paddr            (cfg_paddr),
    .cfg_pwdata           (cfg_pwdata),
    .mismatch_count       (mismatch_count),
    .verdicts_pending     (verdicts_pending)
  );

  // Result side: hold stall for a drawn number of cycles once a result shows, then take it
  always @(negedge clk) begin
    if (out_valid === 1'b1 && stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (out_valid === 1'b1) begin
      out_stall  = 1'b0;
      stall_left = out_burst ? 0 : $urandom_range(0, 11);
    end else begin
      out_stall = ($urandom_range(0, 3) == 0);
    end
  end

  // Primes and base-2 strong pseudoprimes
  function automatic logic [31:0] pool_value(input int idx);
    case (idx)
      0:       return 32'd7919;
      1:       return 32'd65521;
      2:       return 32'd104729;
      3:       return 32'd998244353;
      4:       return 32'd1000000007;
      5:       return 32'd2147483647;
      6:       return 32'd4294967291;
      7:       return 32'd3221225473;
      8:       return 32'd2047;
      9:       return 32'd3277;
      10:      return 32'd4033;
      11:      return 32'd4681;
      12:      return 32'd8321;
      13:      return 32'd15841;
      14:      return 32'd29341;
      default: return 32'd3215031751;
    endcase
  endfunction

  function automatic logic [31:0] pick_candidate();
    logic [63:0] wide;
    int          width;
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 20);
      1, 2, 3: begin
        // narrow odd numbers: quick to test and often prime
        width = $urandom_range(2, 16);
        return ($urandom & ((32'd1 << width) - 32'd1)) | 32'd1;
      end
      4: return $urandom;
      5: return pool_value($urandom_range(0, 15));
      6: return (cur_base >= 32'd2) ? cur_base : $urandom_range(2, 1000);
      7: begin
        // many factors of two in n-1: long squaring chain
        wide = (64'($urandom_range(0, 127)) * 2 + 1) << $urandom_range(1, 30);
        return wide[31:0] + 32'd1;
      end
      8: return 32'hFFFF_FFFF - $urandom_range(0, 64);
      default: return $urandom & ~32'd1;
    endcase
  endfunction

  task automatic send_candidate(input logic [31:0] value);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      @(negedge clk);
      in_valid     = 1'b0;
      in_candidate = $urandom;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     = 1'b1;
    in_candidate = value;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_verdicts();
    @(negedge clk);
    in_valid = 1'b0;
    wait (verdicts_pending == 0);
  endtask

  task automatic cfg_write_base(input logic [31:0] value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = BASE_ADDR;
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cur_base    = value;
  endtask

  initial begin : stimulus
    logic [31:0] bases[8];
    int          p;
    bases = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'd3, $urandom, 32'h8000_0000, 32'd2, $urandom};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset base of two, field extremes, small and even n, pseudoprimes
    foreach (DIRECTED[i]) send_candidate(DIRECTED[i]);

    for (p = 0; p < 8; p++) begin
      drain_verdicts();
      cfg_write_base(bases[p]);
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) send_candidate(pick_candidate());
    end

    drain_verdicts();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && verdicts_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: strong_probable_prime_test_top.f
+incdir+rtl
rtl/sprp_pkg.sv
rtl/sprp_mulmod.sv
rtl/strong_probable_prime_test_top.sv
rtl/sprp_checker.sv
dv/sprp_result_checker.sv
dv/tb_strong_probable_prime_test_top.sv
